// File: hw/rtl/byte_pair_table_unpacker_macros.svh
// ----------------------------------------------------------------------------
// byte_pair_table_unpacker_macros.svh
// assertion shorthands shared by the unpacker modules
// ----------------------------------------------------------------------------
`ifndef BYTE_PAIR_TABLE_UNPACKER_MACROS_SVH
`define BYTE_PAIR_TABLE_UNPACKER_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define BPTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define BPTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bptu_pkg.sv
// ----------------------------------------------------------------------------
// bptu_pkg
// shared types and constants of the byte pair table unpacker
// ----------------------------------------------------------------------------
`default_nettype none

package bptu_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_t;

  typedef enum logic [2:0] {
    PH_ESCAPE = 3'd0,
    PH_COUNT  = 3'd1,
    PH_CODES  = 3'd2,
    PH_VAL_HI = 3'd3,
    PH_VAL_LO = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  localparam int CODE_SPACE  = 256;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [QCNT_W-1:0] qcnt_t;
  typedef logic [QCNT_W:0]   qlvl_t;

  localparam qcnt_t      QUEUE_FULL = qcnt_t'(QUEUE_DEPTH);
  localparam qlvl_t      LEVEL_FULL = qlvl_t'(QUEUE_DEPTH);
  localparam logic [7:0] CODE_START = 8'hFF;

  typedef struct packed {
    logic       pair;
    logic [7:0] first;
    logic [7:0] second;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } req_t;

endpackage

`default_nettype wire

// File: hw/rtl/bptu_ram.sv
// ----------------------------------------------------------------------------
// bptu_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bptu_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/bptu_front.sv
// ----------------------------------------------------------------------------
// bptu_front
// header parser, table writer and lookup pipeline feeding the request queue
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_pair_table_unpacker_macros.svh"

module bptu_front #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bptu_pkg::in_t    in_data,
  input  wire bptu_pkg::qcnt_t  q_count,
  output bptu_pkg::req_t        push
);

  localparam int         IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_LIM = 9'(TABLE_DEPTH);

  bptu_pkg::phase_t phase_r, phase_nxt, phase_eff;
  logic [7:0] esc_code_r, esc_code_nxt;
  logic [7:0] count_r, count_nxt;
  logic [8:0] hc_r, hc_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       esc_pend_r, esc_pend_nxt;
  logic [7:0] held_r, held_nxt;
  logic [bptu_pkg::CODE_SPACE-1:0] hit_r;

  logic       s1_valid_r, s1_valid_nxt, s1_pair_r, s1_pair_nxt;
  logic [7:0] s1_byte_r;
  logic       s2_valid_r, s2_pair_r;
  logic [7:0] s2_byte_r;

  logic             accept, esc_eff, stored, hc_done;
  logic             map_we, val_we, hit_clr;
  logic [7:0]       b, code_new;
  logic [8:0]       hc_inc;
  logic [IDX_W-1:0] map_rdata;
  logic [15:0]      val_rdata;
  bptu_pkg::qlvl_t  level;

  assign accept    = in_valid && !in_stall;
  assign b         = in_data.data_byte;
  assign phase_eff = in_data.stream_start ? bptu_pkg::PH_ESCAPE : phase_r;
  assign esc_eff   = in_data.stream_start ? 1'b0 : esc_pend_r;
  assign code_new  = prev_r + b + 8'd1;
  assign hc_inc    = hc_r + 9'd1;
  assign hc_done   = hc_inc >= {1'b0, count_r};
  assign stored    = hc_r < DEPTH_LIM;

  // room for every request already in flight plus this one
  assign level = {1'b0, q_count}
               + {{bptu_pkg::QCNT_W{1'b0}}, s1_valid_r}
               + {{bptu_pkg::QCNT_W{1'b0}}, s2_valid_r};
  assign in_stall = level >= bptu_pkg::LEVEL_FULL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bptu_pkg::PH_ESCAPE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    esc_code_nxt = esc_code_r;
    count_nxt    = count_r;
    hc_nxt       = hc_r;
    prev_nxt     = prev_r;
    esc_pend_nxt = esc_pend_r;
    held_nxt     = held_r;
    map_we       = 1'b0;
    val_we       = 1'b0;
    hit_clr      = 1'b0;
    s1_valid_nxt = 1'b0;
    s1_pair_nxt  = 1'b0;
    if (accept) begin
      esc_pend_nxt = esc_eff;
      unique case (phase_eff)
        bptu_pkg::PH_ESCAPE: begin
          esc_code_nxt = b;
          esc_pend_nxt = 1'b0;
          prev_nxt     = bptu_pkg::CODE_START;
          hc_nxt       = 9'd0;
          hit_clr      = 1'b1;
          phase_nxt    = bptu_pkg::PH_COUNT;
        end
        bptu_pkg::PH_COUNT: begin
          count_nxt = b;
          hc_nxt    = 9'd0;
          phase_nxt = (b == 8'd0) ? bptu_pkg::PH_DATA : bptu_pkg::PH_CODES;
        end
        bptu_pkg::PH_CODES: begin
          // lowest index wins, so a code already mapped keeps its index
          map_we   = stored && !hit_r[code_new];
          prev_nxt = code_new;
          if (hc_done) begin
            hc_nxt    = 9'd0;
            phase_nxt = bptu_pkg::PH_VAL_HI;
          end else begin
            hc_nxt = hc_inc;
          end
        end
        bptu_pkg::PH_VAL_HI: begin
          held_nxt  = b;
          phase_nxt = bptu_pkg::PH_VAL_LO;
        end
        bptu_pkg::PH_VAL_LO: begin
          val_we = stored;
          if (hc_done) begin
            hc_nxt    = 9'd0;
            phase_nxt = bptu_pkg::PH_DATA;
          end else begin
            hc_nxt    = hc_inc;
            phase_nxt = bptu_pkg::PH_VAL_HI;
          end
        end
        bptu_pkg::PH_DATA: begin
          if (esc_eff) begin
            esc_pend_nxt = 1'b0;
            s1_valid_nxt = 1'b1;
          end else if (b == esc_code_r) begin
            esc_pend_nxt = 1'b1;
          end else begin
            s1_valid_nxt = 1'b1;
            s1_pair_nxt  = hit_r[b];
          end
        end
        default: begin
          phase_nxt = bptu_pkg::PH_ESCAPE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_code_r <= 8'd0;
      count_r    <= 8'd0;
      hc_r       <= 9'd0;
      prev_r     <= bptu_pkg::CODE_START;
      esc_pend_r <= 1'b0;
      held_r     <= 8'd0;
      hit_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      esc_code_r <= esc_code_nxt;
      count_r    <= count_nxt;
      hc_r       <= hc_nxt;
      prev_r     <= prev_nxt;
      esc_pend_r <= esc_pend_nxt;
      held_r     <= held_nxt;
      if (hit_clr) begin
        hit_r <= '0;
      end else if (map_we) begin
        hit_r[code_new] <= 1'b1;
      end
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pair_r <= s1_pair_nxt;
    s1_byte_r <= b;
    s2_pair_r <= s1_pair_r;
    s2_byte_r <= s1_byte_r;
  end

  // code -> first table index holding it
  bptu_ram #(
    .WIDTH (IDX_W),
    .DEPTH (bptu_pkg::CODE_SPACE),
    .ADDR_W(8)
  ) u_map_ram (
    .clk  (clk),
    .we   (map_we),
    .waddr(code_new),
    .wdata(hc_r[IDX_W-1:0]),
    .raddr(b),
    .rdata(map_rdata)
  );

  // table index -> value pair, first arrived byte in the upper half
  bptu_ram #(
    .WIDTH (16),
    .DEPTH (TABLE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_val_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(hc_r[IDX_W-1:0]),
    .wdata({held_r, b}),
    .raddr(map_rdata),
    .rdata(val_rdata)
  );

  assign push.valid        = s2_valid_r;
  assign push.entry.pair   = s2_pair_r;
  assign push.entry.first  = s2_pair_r ? val_rdata[15:8] : s2_byte_r;
  assign push.entry.second = val_rdata[7:0];

  `BPTU_ASSERT_NEXT(a_header_silent, accept && phase_eff != bptu_pkg::PH_DATA, !s1_valid_r,
                    "header byte produced a request")

endmodule

`default_nettype wire

// File: hw/rtl/bptu_fifo.sv
// ----------------------------------------------------------------------------
// bptu_fifo
// short request queue between the lookup front and the output back end
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_pair_table_unpacker_macros.svh"

module bptu_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bptu_pkg::req_t  push,
  input  wire logic            pop,
  output bptu_pkg::req_t       head,
  output bptu_pkg::qcnt_t      count
);

  bptu_pkg::entry_t              mem_r [bptu_pkg::QUEUE_DEPTH];
  logic [bptu_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  bptu_pkg::qcnt_t               count_r;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + bptu_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + bptu_pkg::QPTR_W'(1);
      end
      case ({push.valid, pop})
        2'b10:   count_r <= count_r + bptu_pkg::qcnt_t'(1);
        2'b01:   count_r <= count_r - bptu_pkg::qcnt_t'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head.valid = count_r != '0;
  assign head.entry = mem_r[rd_ptr_r];
  assign count      = count_r;

  `BPTU_ASSERT_NOW(a_no_overflow, push.valid && !pop, count_r != bptu_pkg::QUEUE_FULL,
                   "request pushed into a full queue")
  `BPTU_ASSERT_NOW(a_no_underflow, pop, count_r != '0,
                   "request popped from an empty queue")

endmodule

`default_nettype wire

// File: hw/rtl/bptu_back.sv
// ----------------------------------------------------------------------------
// bptu_back
// output register, splits a pair request into two result bytes
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_pair_table_unpacker_macros.svh"

module bptu_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bptu_pkg::req_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output bptu_pkg::out_t       out_data
);

  logic           out_valid_r, out_valid_nxt;
  bptu_pkg::out_t out_r, out_nxt;
  logic           sec_pend_r, sec_pend_nxt;
  logic [7:0]     sec_byte_r, sec_byte_nxt;
  logic           load_ok;

  assign load_ok = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    sec_pend_nxt  = sec_pend_r;
    sec_byte_nxt  = sec_byte_r;
    pop           = 1'b0;
    if (load_ok) begin
      if (sec_pend_r) begin
        out_valid_nxt        = 1'b1;
        out_nxt.out_byte     = sec_byte_r;
        out_nxt.last_of_run  = 1'b1;
        sec_pend_nxt         = 1'b0;
      end else if (head.valid) begin
        pop                  = 1'b1;
        out_valid_nxt        = 1'b1;
        out_nxt.out_byte     = head.entry.first;
        out_nxt.last_of_run  = !head.entry.pair;
        sec_pend_nxt         = head.entry.pair;
        sec_byte_nxt         = head.entry.second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_pend_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_pend_r  <= sec_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    sec_byte_r <= sec_byte_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BPTU_ASSERT_NOW(a_pair_order, sec_pend_r, out_valid_r && !out_r.last_of_run,
                   "second pair byte waiting without its first byte on the output")

endmodule

`default_nettype wire

// File: hw/rtl/byte_pair_table_unpacker.sv
// ----------------------------------------------------------------------------
// byte_pair_table_unpacker: one byte in per cycle while in_stall is low, one result
// byte out per cycle while out_stall is low; a request passes s1 and s2,
// the queue and the single output register, which sends both bytes of a table hit
// reset: synchronous, clears parse state and queue at once; tables fill from each header
// ----------------------------------------------------------------------------
`default_nettype none

module byte_pair_table_unpacker #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire bptu_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bptu_pkg::out_t      out_data
);

  bptu_pkg::req_t  push;
  bptu_pkg::req_t  head;
  bptu_pkg::qcnt_t q_count;
  logic            pop;

  bptu_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_count (q_count),
    .push    (push)
  );

  bptu_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .head (head),
    .count(q_count)
  );

  bptu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
